@@ sv/assert_macros.svh @@
// assertion macros used by the top level of the pixel clamp block
// each macro checks a property on the rising edge of clk_i, off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on the block clock
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pcba_pkg.sv @@
// shared types and constants of the pixel clamp / recursive box average block
// no dependencies
package pcba_pkg;

  // line store depth, a power of two; the column index wraps modulo this
  localparam int LINE_WIDTH = 1024;
  localparam int ADDR_W     = $clog2(LINE_WIDTH);

  localparam int COORD_W = 10;
  localparam int IN_W    = 16;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;

  localparam int S_FIELDS_W = 2 * COORD_W + 3 * IN_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = 2 * COORD_W + 3 * CHAN_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  localparam int FIFO_DEPTH = 2;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // one result transaction, x in the lowest bits
  typedef struct packed {
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } pix_out_t;

  // status of the output queue seen by the pipeline
  typedef struct packed {
    logic             full;
    logic [CNT_W-1:0] count;
  } fifo_stat_t;

endpackage

@@ sv/pcba_lane.sv @@
// one colour channel lane: q8.8 scale by 255 with clamp, then optional 2x2 average
// depends on pcba_pkg
module pcba_lane import pcba_pkg::*; (
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic signed [IN_W-1:0]   chan_i,
  input  logic                     avg_en_i,
  input  logic        [CHAN_W-1:0] left_i,
  input  logic        [CHAN_W-1:0] up_i,
  input  logic        [CHAN_W-1:0] upleft_i,
  output logic        [CHAN_W-1:0] result_o
);

  logic [IN_W+CHAN_W-1:0] prod;
  logic [IN_W-1:0]        prod_hi;
  logic [CHAN_W-1:0]      scaled_d, scaled_q;
  logic [CHAN_W+1:0]      sum;

  // v * 255 = (v << 8) - v, then >> 8 and saturate
  always_comb begin
    prod    = {chan_i, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, chan_i};
    prod_hi = prod[IN_W+CHAN_W-1:CHAN_W];
    if (chan_i[IN_W-1] || (chan_i == '0)) begin
      scaled_d = '0;
    end else if (|prod_hi[IN_W-1:CHAN_W]) begin
      scaled_d = {CHAN_W{1'b1}};
    end else begin
      scaled_d = prod_hi[CHAN_W-1:0];
    end
  end

  // clamped value held while the pixel waits for its upper neighbour
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      scaled_q <= scaled_d;
    end
  end

  // floor of the four-pixel mean when averaging is enabled, else the clamped value
  always_comb begin
    sum = {2'b00, scaled_q} + {2'b00, left_i} + {2'b00, up_i} + {2'b00, upleft_i};
    result_o = avg_en_i ? sum[CHAN_W+1:2] : scaled_q;
  end

endmodule

@@ sv/pcba_line_ram.sv @@
// one-row line store of filtered pixels, one write and one registered read port
// depends on pcba_pkg
module pcba_line_ram import pcba_pkg::*; (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [PIX_W-1:0]  rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [PIX_W-1:0]  wr_data_i
);

  logic [PIX_W-1:0] mem [LINE_WIDTH];
  logic [PIX_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/pcba_out_fifo.sv @@
// two-entry output queue of the merged result transactions
// depends on pcba_pkg
module pcba_out_fifo import pcba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pix_out_t             push_data_i,
  output fifo_stat_t           stat_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  pix_out_t         mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;

  assign pop = (count_q != '0) && m_axis_tready_i;

  // occupancy
  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  // entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign stat_o.full     = (count_q == CNT_W'(FIFO_DEPTH));
  assign stat_o.count    = count_q;
  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, mem_q[rd_ptr_q]};

endmodule

@@ sv/pixel_clamp_recursive_box_average.sv @@
// top level of the pixel clamp with recursive 2x2 box average
// depends on pcba_pkg, pcba_lane, pcba_line_ram, pcba_out_fifo, assert_macros.svh
//
// Usage:
//   Pixels enter in raster order on the s_axis channel, one transaction per
//   pixel; each gives exactly one m_axis transaction with the stored colour.
//   cfg_we_i writes aa_enable from cfg_wdata_i; write it only while idle.
//   Throughput is one pixel per cycle while the output queue is not full. An input
//   transaction registers the pixel and the line store read into the stage
//   registers; the stage then averages with the left, up and up-left pixels,
//   writes back and queues the pixel, and m_axis_tvalid rises from the queue.
//   The three colour channels run in parallel lanes; the top level packs
//   their results into one transaction for the output queue.
//   The left neighbour is fed back from the value written in the same cycle,
//   so the average and its writeback happen in the same cycle.
//   A two-entry output queue decouples the sides: s_axis_tready drops only
//   when the queue is full and a pixel is waiting to enter it.
//   Reset clears aa_enable, the neighbour registers and the queue. The line
//   store has no reset; each entry must be written (row zero) before it is
//   used as an upper neighbour.
module pixel_clamp_recursive_box_average import pcba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_wdata_i,     // aa_enable
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // pix_x[9:0], pix_y[19:10], red_in[35:20], green_in[51:36], blue_in[67:52]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_x[9:0], out_y[19:10], red_out[27:20], green_out[35:28], blue_out[43:36]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  `include "assert_macros.svh"

  logic                      aa_en_q;
  logic                      acc, a_move;
  logic                      valid_a_q, avg_q;
  logic [COORD_W-1:0]        x_q, y_q;
  logic [COORD_W-1:0]        in_x, in_y;
  logic [ADDR_W-1:0]         rd_addr, wr_addr;
  logic [PIX_W-1:0]          ram_rd, up, packed_pix;
  logic [PIX_W-1:0]          left_q, upleft_q, fwd_data_q;
  logic                      fwd_hit_q;
  logic [2:0][CHAN_W-1:0]    lane_res;
  logic [2:0][IN_W-1:0]      lane_in;
  pix_out_t                  push_data;
  fifo_stat_t                fifo_stat;

  // input field unpacking
  assign in_x = s_axis_tdata[COORD_W-1:0];
  assign in_y = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign lane_in[2] = s_axis_tdata[2*COORD_W+IN_W-1:2*COORD_W];
  assign lane_in[1] = s_axis_tdata[2*COORD_W+2*IN_W-1:2*COORD_W+IN_W];
  assign lane_in[0] = s_axis_tdata[2*COORD_W+3*IN_W-1:2*COORD_W+2*IN_W];

  // handshake and stage advance
  assign a_move        = valid_a_q && !fifo_stat.full;
  assign s_axis_tready = !valid_a_q || !fifo_stat.full;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign rd_addr = ADDR_W'(in_x);
  assign wr_addr = ADDR_W'(x_q);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aa_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      aa_en_q <= cfg_wdata_i[0];
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (acc) begin
      valid_a_q <= 1'b1;
    end else if (a_move) begin
      valid_a_q <= 1'b0;
    end
  end

  // stage payload and same-address forwarding from the pixel leaving now
  always_ff @(posedge clk_i) begin
    if (acc) begin
      x_q        <= in_x;
      y_q        <= in_y;
      avg_q      <= aa_en_q && (in_x != '0) && (in_y != '0);
      fwd_hit_q  <= a_move && (wr_addr == rd_addr);
      fwd_data_q <= packed_pix;
    end
  end

  assign up = fwd_hit_q ? fwd_data_q : ram_rd;

  // neighbour registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      upleft_q <= '0;
    end else if (a_move) begin
      left_q   <= packed_pix;
      upleft_q <= up;
    end
  end

  // colour lanes, red in the top byte of a packed pixel
  for (genvar i = 0; i < 3; i++) begin : g_lane
    pcba_lane u_lane (
      .clk_i    (clk_i),
      .load_i   (acc),
      .chan_i   (lane_in[i]),
      .avg_en_i (avg_q),
      .left_i   (left_q[i*CHAN_W +: CHAN_W]),
      .up_i     (up[i*CHAN_W +: CHAN_W]),
      .upleft_i (upleft_q[i*CHAN_W +: CHAN_W]),
      .result_o (lane_res[i])
    );
  end

  assign packed_pix = {lane_res[2], lane_res[1], lane_res[0]};

  pcba_line_ram u_line (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rd),
    .wr_en_i   (a_move),
    .wr_addr_i (wr_addr),
    .wr_data_i (packed_pix)
  );

  // merge the lanes into one result transaction
  always_comb begin
    push_data.x     = x_q;
    push_data.y     = y_q;
    push_data.red   = lane_res[2];
    push_data.green = lane_res[1];
    push_data.blue  = lane_res[0];
  end

  pcba_out_fifo u_fifo (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (a_move),
    .push_data_i     (push_data),
    .stat_o          (fifo_stat),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  // checks
  `ASSERT_CLK(a_fifo_bound, fifo_stat.count <= CNT_W'(FIFO_DEPTH), "output queue overflow")
  `ASSERT_NEXT(a_stall_holds, valid_a_q && !a_move, valid_a_q, "waiting pixel dropped")
  `ASSERT_NEXT(a_fwd_taken, acc && a_move && (wr_addr == rd_addr), fwd_hit_q,
               "same-column write not forwarded")
  `ASSERT_CLK(a_tvalid_count, m_axis_tvalid == (fifo_stat.count != '0),
              "result valid disagrees with queue fill")

endmodule
